>>> sv/ktd_pkg.sv
// ----------------------------------------------------------------------------
// ktd_pkg
// shared types and constants for the keyframe translation delta core
// ----------------------------------------------------------------------------
package ktd_pkg;

	localparam int MaxKeys = 64;
	localparam int IdxW    = $clog2(MaxKeys);
	localparam int CntW    = $clog2(MaxKeys + 1);

	localparam logic [0:0] CFG_KEY_COUNT = 1'b0;
	localparam logic [0:0] CFG_DURATION  = 1'b1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [5:0]         key_index;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        start_time;
		logic [31:0]        end_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [31:0] delta_z;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL,     // pick next sample time
		ST_READ,    // issue table read for current key
		ST_CMP,     // compare key time against sample
		ST_DIV,     // iterative alpha division
		ST_MUL,     // per-axis lerp multiply
		ST_ACC,     // fold sample into accumulator
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // write key into table
		logic       capture;   // latch query times
		logic       sel_init;  // reset walk for new sample
		logic       rd;        // read key at walk index
		logic       step;      // key passed: becomes previous key
		logic       hold;      // walk ended: sample = previous key
		logic       div_start;
		logic       mul_start;
		logic       acc;       // accumulate current sample
		logic       emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       walk_end;   // index reached key count, capped at MaxKeys
		logic       hit;        // sample time <= key time
		logic       div_done;
		logic       mul_done;
		logic       last_sample;
	} stat_t;

endpackage

>>> sv/ktd_ctrl.sv
// ----------------------------------------------------------------------------
// ktd_ctrl
// sequencer for the keyframe walk, division and lerp of each sample
// ----------------------------------------------------------------------------
module ktd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  ktd_pkg::stat_t   stat,
	output ktd_pkg::cmd_t    cmd,
	output logic             busy
);

	ktd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ktd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ktd_pkg::ST_IDLE: begin
				if (start && mode == ktd_pkg::MODE_QUERY) state_d = ktd_pkg::ST_SEL;
			end
			ktd_pkg::ST_SEL:  state_d = ktd_pkg::ST_READ;
			ktd_pkg::ST_READ: begin
				if (stat.walk_end) state_d = ktd_pkg::ST_ACC;
				else state_d = ktd_pkg::ST_CMP;
			end
			ktd_pkg::ST_CMP: begin
				if (stat.hit) state_d = ktd_pkg::ST_DIV;
				else state_d = ktd_pkg::ST_READ;
			end
			ktd_pkg::ST_DIV: begin
				if (stat.div_done) state_d = ktd_pkg::ST_MUL;
			end
			ktd_pkg::ST_MUL: begin
				if (stat.mul_done) state_d = ktd_pkg::ST_ACC;
			end
			ktd_pkg::ST_ACC: begin
				if (stat.last_sample) state_d = ktd_pkg::ST_DONE;
				else state_d = ktd_pkg::ST_SEL;
			end
			ktd_pkg::ST_DONE: state_d = ktd_pkg::ST_IDLE;
			default: state_d = ktd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ktd_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start && mode == ktd_pkg::MODE_LOAD;
				cmd.capture = start && mode == ktd_pkg::MODE_QUERY;
			end
			ktd_pkg::ST_SEL:  cmd.sel_init = 1'b1;
			ktd_pkg::ST_READ: begin
				cmd.rd = !stat.walk_end;
				cmd.hold = stat.walk_end;
			end
			ktd_pkg::ST_CMP: begin
				cmd.div_start = stat.hit;
				cmd.step = !stat.hit;
			end
			ktd_pkg::ST_DIV: cmd.mul_start = stat.div_done;
			ktd_pkg::ST_MUL: ;
			ktd_pkg::ST_ACC:  cmd.acc = 1'b1;
			ktd_pkg::ST_DONE: cmd.emit = 1'b1;
			default: ;
		endcase
	end

endmodule

>>> sv/ktd_dp.sv
// ----------------------------------------------------------------------------
// ktd_dp
// key table, alpha divider, lerp multiplier and accumulator with saturating output
// ----------------------------------------------------------------------------
module ktd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ktd_pkg::in_item_t  item,
	input  logic [6:0]         key_count,
	input  logic [31:0]        motion_duration,
	input  ktd_pkg::cmd_t      cmd,
	output ktd_pkg::stat_t     stat,
	output ktd_pkg::out_item_t result,
	output logic               result_valid
);

	// key table, one read port with registered data
	logic [127:0] mem [ktd_pkg::MaxKeys];
	logic [127:0] rd_q;

	logic [31:0] t0_q, t1_q, ts_q;
	logic        wrap_q;
	logic [1:0]  smp_q;       // 0:t0 1:t1 2:duration
	logic [ktd_pkg::CntW-1:0] idx_q;
	logic [ktd_pkg::CntW-1:0] n_lim;

	logic [31:0]        pt_q;
	logic signed [31:0] pv_q [3];
	logic signed [31:0] kv_q [3];
	logic [31:0]        kt_q;
	logic signed [31:0] sv_q [3];  // sampled value
	logic signed [34:0] acc_q [3];

	// divider: alpha = ((t-pt)<<16)/span, quotient capped at 17 bits
	logic [48:0] rem_q;
	logic [31:0] span_q;
	logic [16:0] quo_q;
	logic [5:0]  dcnt_q;
	logic        div_busy_q;
	logic [16:0] alpha_q;

	// multiplier: one axis per cycle
	logic [1:0]  mcnt_q;
	logic        mul_busy_q;
	logic signed [32:0] diff;
	logic signed [50:0] prod;
	logic signed [34:0] prod_sh;

	assign n_lim = (key_count > 7'(ktd_pkg::MaxKeys))
		? ktd_pkg::CntW'(ktd_pkg::MaxKeys) : ktd_pkg::CntW'(key_count);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[item.key_index[ktd_pkg::IdxW-1:0]] <=
				{item.key_time, item.key_x, item.key_y, item.key_z};
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q[ktd_pkg::IdxW-1:0]];
		end
	end

	always_comb begin
		kt_q    = rd_q[127:96];
		kv_q[0] = rd_q[95:64];
		kv_q[1] = rd_q[63:32];
		kv_q[2] = rd_q[31:0];
	end

	assign stat.walk_end    = idx_q == n_lim;
	assign stat.hit         = ts_q <= kt_q;
	assign stat.div_done    = div_busy_q && dcnt_q == 6'd0;
	assign stat.mul_done    = mul_busy_q && mcnt_q == 2'd2;
	assign stat.last_sample = wrap_q ? (smp_q == 2'd2) : (smp_q == 2'd1);

	assign diff    = 33'(kv_q[mcnt_q]) - 33'(pv_q[mcnt_q]);
	assign prod    = 51'(diff) * $signed({34'd0, alpha_q});
	assign prod_sh = 35'(prod >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q   <= 1'b0;
			mul_busy_q   <= 1'b0;
			result_valid <= 1'b0;
			smp_q        <= 2'd0;
		end else begin
			result_valid <= cmd.emit;
			if (cmd.capture) begin
				t0_q   <= item.start_time;
				t1_q   <= item.end_time;
				wrap_q <= item.end_time < item.start_time;
				smp_q  <= 2'd0;
				for (int k = 0; k < 3; k++) acc_q[k] <= '0;
			end
			if (cmd.sel_init) begin
				ts_q  <= (smp_q == 2'd0) ? t0_q : (smp_q == 2'd1) ? t1_q : motion_duration;
				idx_q <= '0;
				pt_q  <= '0;
				for (int k = 0; k < 3; k++) pv_q[k] <= '0;
			end
			if (cmd.rd) idx_q <= idx_q + 1'b1;
			if (cmd.step) begin
				pt_q <= kt_q;
				for (int k = 0; k < 3; k++) pv_q[k] <= kv_q[k];
			end
			if (cmd.hold) begin
				for (int k = 0; k < 3; k++) sv_q[k] <= pv_q[k];
			end
			if (cmd.div_start) begin
				span_q     <= kt_q - pt_q;
				rem_q      <= {1'b0, ts_q - pt_q, 16'd0};
				quo_q      <= '0;
				dcnt_q     <= 6'd17;
				div_busy_q <= 1'b1;
			end else if (div_busy_q) begin
				if (dcnt_q == 6'd0) begin
					alpha_q    <= quo_q;
					div_busy_q <= 1'b0;
				end else if (span_q == 32'd0) begin
					// zero span: alpha is one
					quo_q  <= 17'd65536;
					dcnt_q <= 6'd0;
				end else begin
					// restoring step on bit dcnt-1 (quotient fits 17 bits)
					if ((rem_q >> (dcnt_q - 6'd1)) >= 49'(span_q)) begin
						rem_q <= rem_q - (49'(span_q) << (dcnt_q - 6'd1));
						quo_q <= quo_q | (17'd1 << (dcnt_q - 6'd1));
					end
					dcnt_q <= dcnt_q - 6'd1;
				end
			end
			if (cmd.mul_start) begin
				mcnt_q     <= 2'd0;
				mul_busy_q <= 1'b1;
			end else if (mul_busy_q) begin
				sv_q[mcnt_q] <= 32'(35'(pv_q[mcnt_q]) + prod_sh);
				if (mcnt_q == 2'd2) mul_busy_q <= 1'b0;
				else mcnt_q <= mcnt_q + 2'd1;
			end
			if (cmd.acc) begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= (smp_q == 2'd0) ? acc_q[k] - 35'(sv_q[k])
					                            : acc_q[k] + 35'(sv_q[k]);
				end
				smp_q <= smp_q + 2'd1;
			end
		end
	end

	function automatic logic [31:0] sat(input logic signed [34:0] v);
		if (v > 35'sd2147483647) return 32'h7fffffff;
		if (v < -35'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	assign result.delta_x = sat(acc_q[0]);
	assign result.delta_y = sat(acc_q[1]);
	assign result.delta_z = sat(acc_q[2]);

endmodule

>>> sv/keyframe_translation_delta_core.sv
// ----------------------------------------------------------------------------
// keyframe_translation_delta_core
// translation keyframe table with interval displacement queries
// ----------------------------------------------------------------------------
// load item: written to the key table while idle, busy stays low, no result
// query item: per sample a select step and a read and compare per key; at the hit key
//   the alpha division (shorter on a zero span) and the per-axis lerp, or a hold past
// the last key; then an accumulate step; two or three samples and a finish step
// one item at a time; result strobes one cycle as busy drops and cannot be stalled
// reset clears control and config registers; key table contents are undefined
module keyframe_translation_delta_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ktd_pkg::in_item_t  item,
	output logic               done,
	output ktd_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// configuration registers
	logic [6:0]  key_count_q;
	logic [31:0] duration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			duration_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ktd_pkg::CFG_KEY_COUNT: key_count_q <= cfg_data[6:0];
				ktd_pkg::CFG_DURATION:  duration_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ktd_pkg::cmd_t  cmd;
	ktd_pkg::stat_t stat;

	// sequencer
	ktd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table and arithmetic
	ktd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.key_count       (key_count_q),
		.motion_duration (duration_q),
		.cmd             (cmd),
		.stat            (stat),
		.result          (result),
		.result_valid    (done)
	);

endmodule

>>> sv/ktd_checker.sv
// ----------------------------------------------------------------------------
// ktd_checker
// port-level checks on the keyframe translation delta core
// ----------------------------------------------------------------------------
module ktd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic mode
);

	// a query makes the block busy next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode |=> busy) else $error("query not taken");

	// a load never makes it busy
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !mode |=> !busy) else $error("load held block");

	// a result comes while idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// result strobe is one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe too long");

	// busy ends exactly with a result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy ended without result");

endmodule

bind keyframe_translation_delta_core ktd_checker u_ktd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.mode   (item.mode)
);
